>>> rtl/pmf_pkg.sv
`timescale 1ns / 1ps

package pmf_pkg;

	// Configuration port
	localparam int APB_AW = 5;

	// Multiplier first operand: a 32-bit signed gain or the 17-bit filter weight
	localparam int GAIN_W = 33;

	// Filter weight, unsigned Q1.16 (WEIGHT_ONE is 1.0)
	localparam int WEIGHT_BITS = 16;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;

	typedef enum logic [2:0] {
		REG_PROP    = 3'd0,
		REG_INTEG   = 3'd1,
		REG_DERIV   = 3'd2,
		REG_WEIGHT  = 3'd3,
		REG_PERIOD  = 3'd4,
		REG_DMIN    = 3'd5,
		REG_DMAX    = 3'd6,
		REG_VARIANT = 3'd7
	} reg_idx_t;

	// Scaling applied after a product
	typedef enum logic [1:0] {
		SH_FRAC,
		SH_HALF,
		SH_WEIGHT
	} shift_sel_t;

	typedef struct packed {
		logic       start;
		shift_sel_t sh;
	} mul_req_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_LO,
		MP_HI,
		MP_FIN
	} mul_phase_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ERR,
		ST_DMEAS,
		ST_M_INT,
		ST_W_INT,
		ST_M_PROP,
		ST_W_PROP,
		ST_CLAMP_S,
		ST_FDIFF,
		ST_M_FILT,
		ST_W_FILT,
		ST_M_DER,
		ST_W_DER,
		ST_ADD,
		ST_PDIFF,
		ST_SUBF,
		ST_CLAMP_OUT,
		ST_DONE
	} pid_state_t;

endpackage

>>> rtl/pmf_if.sv
`timescale 1ns / 1ps

interface pmf_in_if;
	logic              valid;
	logic              ready;
	logic [31:0]       now_ms;
	logic signed [31:0] target;
	logic signed [31:0] measured;

	modport source(output valid, now_ms, target, measured, input ready);
	modport sink(input valid, now_ms, target, measured, output ready);
endinterface

interface pmf_out_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] drive;
	logic              stepped;

	modport source(output valid, drive, stepped, input ready);
	modport sink(input valid, drive, stepped, output ready);
endinterface

>>> rtl/pmf_mul.sv
`timescale 1ns / 1ps

module pmf_mul import pmf_pkg::*; #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mul_req_t                req,
	input  logic signed [GAIN_W-1:0] a,
	input  logic signed [DW:0]      b,
	output logic signed [DW-1:0]    res,
	output logic                    done
);

	localparam int BW  = DW + 1;
	localparam int H   = (BW + 1) / 2;
	localparam int CW  = H + 1;
	localparam int PPW = GAIN_W + CW;
	localparam int PW  = GAIN_W + BW;
	localparam logic signed [PW-1:0] RMAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [PW-1:0] RMIN = ~RMAX;

	mul_phase_t              phase_q, phase_d;
	logic signed [GAIN_W-1:0] a_q;
	logic signed [BW-1:0]    b_q;
	shift_sel_t              sh_q;
	logic signed [PW-1:0]    acc_q;
	logic signed [DW-1:0]    res_q;
	logic                    done_q;
	logic                    take, ld_lo, ld_hi, fin;
	logic signed [CW-1:0]    chunk;
	logic signed [PPW-1:0]   prod;
	logic signed [PW-1:0]    shifted;
	logic signed [DW-1:0]    sat_res;

	// Advance through low half, high half and scaling
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			MP_IDLE: if (req.start) phase_d = MP_LO;
			MP_LO:   phase_d = MP_HI;
			MP_HI:   phase_d = MP_FIN;
			MP_FIN:  phase_d = MP_IDLE;
			default: phase_d = MP_IDLE;
		endcase
	end

	always_comb begin
		take  = 1'b0;
		ld_lo = 1'b0;
		ld_hi = 1'b0;
		fin   = 1'b0;
		case (phase_q)
			MP_IDLE: take  = req.start;
			MP_LO:   ld_lo = 1'b1;
			MP_HI:   ld_hi = 1'b1;
			MP_FIN:  fin   = 1'b1;
			default: take  = 1'b0;
		endcase
	end

	// Low half unsigned, high half signed
	always_comb begin
		if (phase_q == MP_LO) begin
			chunk = $signed({1'b0, b_q[H-1:0]});
		end else begin
			chunk = CW'($signed(b_q[BW-1:H]));
		end
	end

	assign prod = a_q * chunk;

	// Floor scaling then saturation to the data range
	always_comb begin
		case (sh_q)
			SH_FRAC:   shifted = acc_q >>> FB;
			SH_HALF:   shifted = acc_q >>> (FB + 1);
			SH_WEIGHT: shifted = acc_q >>> WEIGHT_BITS;
			default:   shifted = acc_q >>> FB;
		endcase
		if (shifted > RMAX) begin
			sat_res = RMAX[DW-1:0];
		end else if (shifted < RMIN) begin
			sat_res = RMIN[DW-1:0];
		end else begin
			sat_res = shifted[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= fin;
		end
	end

	// Hold operands, accumulate partial products
	always_ff @(posedge clk) begin
		if (take) begin
			a_q  <= a;
			b_q  <= b;
			sh_q <= req.sh;
		end
		if (ld_lo) acc_q <= PW'(prod);
		if (ld_hi) acc_q <= acc_q + (PW'(prod) <<< H);
		if (fin) res_q <= sat_res;
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

>>> rtl/pid_measurement_filtered.sv
`timescale 1ns / 1ps
// Channel   Modport  Moves                                  Accepted when
// sample    sink     now_ms, target, measured               valid & ready
// result    source   drive, stepped                         valid & ready
// apb       slave    8 registers at 4*index, 32-bit data    psel & penable & pwrite
//
// One request at a time. A sample that causes no step goes straight to the result register;
// a control step (variant 0 or variant 1) runs four products on the one shared multiplier,
// each through issue, two partial products, scaling and hand-back, with the adds and
// clamps between them.
// Reset clears control state, configuration and the controller state at once.
// The result register holds until taken; a finished step waits in the final state for it.

module pid_measurement_filtered import pmf_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	pmf_in_if.sink            sample,
	pmf_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int DW = DATA_WIDTH;
	localparam int EW = ((DW > 32) ? DW : 32) + 2;
	localparam logic signed [EW-1:0] DMAX_E = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [EW-1:0] DMIN_E = ~DMAX_E;
	localparam logic signed [EW-1:0] OMAX_E = {{(EW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [EW-1:0] OMIN_E = ~OMAX_E;

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [EW-1:0] x);
		if (x > DMAX_E) return DMAX_E[DW-1:0];
		else if (x < DMIN_E) return DMIN_E[DW-1:0];
		else return x[DW-1:0];
	endfunction

	function automatic logic signed [31:0] sat_out(input logic signed [EW-1:0] x);
		if (x > OMAX_E) return OMAX_E[31:0];
		else if (x < OMIN_E) return OMIN_E[31:0];
		else return x[31:0];
	endfunction

	// Configuration registers
	logic signed [31:0] prop_q, integ_q, deriv_q, dmin_q, dmax_q;
	logic [16:0]        fw_q;
	logic [15:0]        period_q;
	logic               variant_q;

	// Controller state
	logic [31:0]          last_q;
	logic signed [DW-1:0] pe_q, pm_q, isum_q, drive_q, filt_q, pdrive_q;

	// Working registers
	pid_state_t           state_q, state_d;
	logic [31:0]          now_q;
	logic signed [DW-1:0] tgt_q, meas_q, err_q, dmeas_q, acc_q, x_q;
	logic                 stepped_q;

	// Result register
	logic                 out_valid_q;
	logic signed [31:0]   out_drive_q;
	logic                 out_stepped_q;

	logic                 cfg_wr, step, out_free;
	logic [31:0]          dt;
	logic signed [DW-1:0] lo_dw, hi_dw, cl_res, alu_a, alu_b, alu_res;
	logic signed [EW-1:0] alu_sum;
	logic                 alu_sub;
	logic                 we_err, we_dmeas, we_acc, we_x, we_filt, we_isum;
	logic                 we_chk, we_fin, out_load;
	logic [16:0]          w_eff;
	logic signed [DW:0]   esum;
	mul_req_t             mreq;
	logic signed [GAIN_W-1:0] mul_a;
	logic signed [DW:0]   mul_b;
	logic signed [DW-1:0] mul_res;
	logic                 mul_done;

	pmf_mul #(.DW(DW), .FB(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res),
		.done   (mul_done)
	);

	// Register writes and reads
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q    <= '0;
			integ_q   <= '0;
			deriv_q   <= '0;
			fw_q      <= WEIGHT_ONE;
			period_q  <= 16'd1;
			dmin_q    <= 32'sh8000_0000;
			dmax_q    <= 32'sh7fff_ffff;
			variant_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_PROP:    prop_q    <= pwdata;
				REG_INTEG:   integ_q   <= pwdata;
				REG_DERIV:   deriv_q   <= pwdata;
				REG_WEIGHT:  fw_q      <= pwdata[16:0];
				REG_PERIOD:  period_q  <= pwdata[15:0];
				REG_DMIN:    dmin_q    <= pwdata;
				REG_DMAX:    dmax_q    <= pwdata;
				REG_VARIANT: variant_q <= pwdata[0];
				default:     variant_q <= variant_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_PROP:    prdata = prop_q;
			REG_INTEG:   prdata = integ_q;
			REG_DERIV:   prdata = deriv_q;
			REG_WEIGHT:  prdata = {15'b0, fw_q};
			REG_PERIOD:  prdata = {16'b0, period_q};
			REG_DMIN:    prdata = dmin_q;
			REG_DMAX:    prdata = dmax_q;
			REG_VARIANT: prdata = {31'b0, variant_q};
			default:     prdata = '0;
		endcase
	end

	// Shared add/subtract with saturation, and the clamp
	assign lo_dw   = sat_dw(EW'(dmin_q));
	assign hi_dw   = sat_dw(EW'(dmax_q));
	assign alu_sum = alu_sub ? (EW'(alu_a) - EW'(alu_b)) : (EW'(alu_a) + EW'(alu_b));
	assign alu_res = sat_dw(alu_sum);
	assign cl_res  = (acc_q > hi_dw) ? hi_dw : ((acc_q < lo_dw) ? lo_dw : acc_q);

	assign dt       = now_q - last_q;
	assign step     = dt >= {16'b0, period_q};
	assign w_eff    = (fw_q > WEIGHT_ONE) ? WEIGHT_ONE : fw_q;
	assign esum     = (DW+1)'(err_q) + (DW+1)'(pe_q);
	assign out_free = !out_valid_q || result.ready;

	// Sequence the step
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (sample.valid) state_d = ST_CHECK;
			ST_CHECK:     state_d = step ? ST_ERR : ST_DONE;
			ST_ERR:       state_d = ST_DMEAS;
			ST_DMEAS:     state_d = ST_M_INT;
			ST_M_INT:     state_d = ST_W_INT;
			ST_W_INT:     if (mul_done) state_d = ST_M_PROP;
			ST_M_PROP:    state_d = ST_W_PROP;
			ST_W_PROP:    if (mul_done) state_d = ST_CLAMP_S;
			ST_CLAMP_S:   state_d = variant_q ? ST_M_DER : ST_FDIFF;
			ST_FDIFF:     state_d = ST_M_FILT;
			ST_M_FILT:    state_d = ST_W_FILT;
			ST_W_FILT:    if (mul_done) state_d = variant_q ? ST_SUBF : ST_M_DER;
			ST_M_DER:     state_d = ST_W_DER;
			ST_W_DER:     if (mul_done) state_d = ST_ADD;
			ST_ADD:       state_d = variant_q ? ST_PDIFF : ST_CLAMP_OUT;
			ST_PDIFF:     state_d = ST_FDIFF;
			ST_SUBF:      state_d = ST_CLAMP_OUT;
			ST_CLAMP_OUT: state_d = ST_DONE;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Steer operands and write enables for each state
	always_comb begin
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		we_err   = 1'b0;
		we_dmeas = 1'b0;
		we_acc   = 1'b0;
		we_x     = 1'b0;
		we_filt  = 1'b0;
		we_isum  = 1'b0;
		we_chk   = 1'b0;
		we_fin   = 1'b0;
		out_load = 1'b0;
		mreq     = '{start: 1'b0, sh: SH_FRAC};
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_CHECK: we_chk = 1'b1;
			ST_ERR: begin
				alu_a = tgt_q; alu_b = meas_q; alu_sub = 1'b1; we_err = 1'b1;
			end
			ST_DMEAS: begin
				alu_a = meas_q; alu_b = pm_q; alu_sub = 1'b1; we_dmeas = 1'b1;
			end
			ST_M_INT: begin
				mreq  = '{start: 1'b1, sh: SH_HALF};
				mul_a = GAIN_W'(integ_q);
				mul_b = esum;
			end
			ST_W_INT: begin
				alu_a = isum_q; alu_b = mul_res; we_acc = mul_done;
			end
			ST_M_PROP: begin
				mreq  = '{start: 1'b1, sh: SH_FRAC};
				mul_a = GAIN_W'(prop_q);
				mul_b = (DW+1)'(dmeas_q);
			end
			ST_W_PROP: begin
				alu_a = acc_q; alu_b = mul_res; alu_sub = 1'b1; we_acc = mul_done;
			end
			ST_CLAMP_S: we_isum = 1'b1;
			ST_FDIFF: begin
				alu_a = variant_q ? x_q : dmeas_q; alu_b = filt_q; alu_sub = 1'b1;
				we_x = 1'b1;
			end
			ST_M_FILT: begin
				mreq  = '{start: 1'b1, sh: SH_WEIGHT};
				mul_a = $signed({16'b0, w_eff});
				mul_b = (DW+1)'(x_q);
			end
			ST_W_FILT: begin
				alu_a = filt_q; alu_b = mul_res; we_filt = mul_done;
			end
			ST_M_DER: begin
				mreq  = '{start: 1'b1, sh: SH_FRAC};
				mul_a = GAIN_W'(deriv_q);
				mul_b = variant_q ? (DW+1)'(dmeas_q) : (DW+1)'(filt_q);
			end
			ST_W_DER: begin
				alu_a = isum_q; alu_b = mul_res; alu_sub = 1'b1; we_acc = mul_done;
			end
			ST_ADD: begin
				alu_a = drive_q; alu_b = acc_q; we_acc = 1'b1;
			end
			ST_PDIFF: begin
				alu_a = acc_q; alu_b = pdrive_q; alu_sub = 1'b1; we_x = 1'b1;
			end
			ST_SUBF: begin
				alu_a = acc_q; alu_b = filt_q; alu_sub = 1'b1; we_acc = 1'b1;
			end
			ST_CLAMP_OUT: we_fin = 1'b1;
			ST_DONE: out_load = out_free;
			default: we_chk = 1'b0;
		endcase
	end

	assign sample.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			stepped_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we_chk) stepped_q <= step;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Controller state: change only on a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			pe_q     <= '0;
			pm_q     <= '0;
			isum_q   <= '0;
			drive_q  <= '0;
			filt_q   <= '0;
			pdrive_q <= '0;
		end else begin
			if (we_isum) isum_q <= cl_res;
			if (we_filt) filt_q <= alu_res;
			if (we_fin) begin
				drive_q <= cl_res;
				if (variant_q) pdrive_q <= cl_res;
				pe_q   <= err_q;
				pm_q   <= meas_q;
				last_q <= now_q;
			end
		end
	end

	// Capture the request and hold intermediate values
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			now_q  <= sample.now_ms;
			tgt_q  <= sat_dw(EW'(sample.target));
			meas_q <= sat_dw(EW'(sample.measured));
		end
		if (we_err) err_q <= alu_res;
		if (we_dmeas) dmeas_q <= alu_res;
		if (we_acc) acc_q <= alu_res;
		if (we_x) x_q <= alu_res;
		if (out_load) begin
			out_drive_q   <= sat_out(EW'(drive_q));
			out_stepped_q <= stepped_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.drive   = out_drive_q;
	assign result.stepped = out_stepped_q;

	// Products come back only while the sequencer waits for one
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_W_INT || state_q == ST_W_PROP ||
			state_q == ST_W_FILT || state_q == ST_W_DER))
		else $error("product returned outside a wait state");

	// A new result appears only from the final state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the final state");

	// After a step the integral sum lies within ordered limits
	a_isum_rng: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && stepped_q && lo_dw <= hi_dw) |->
			(isum_q >= lo_dw && isum_q <= hi_dw))
		else $error("integral sum outside limits");

	// After a step the drive lies within ordered limits
	a_drive_rng: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && stepped_q && lo_dw <= hi_dw) |->
			(drive_q >= lo_dw && drive_q <= hi_dw))
		else $error("drive outside limits");

endmodule
